// ===== sv/clbm_pkg.sv =====
// Shared types, constants and step functions for the combined LFSR byte masker.
// No dependencies; used by clbm_keystream and combined_lfsr_byte_masker_unit.
`default_nettype none

package clbm_pkg;

  localparam int SHORT_W  = 16;
  localparam int LONG_W   = 108;
  localparam int BYTE_W   = 8;
  localparam int MLEN_W   = 32;
  localparam int SHORT_TAP = 6;
  localparam int LONG_TAP  = 30;

  localparam logic [SHORT_W-1:0] SHORT_INIT = 16'b1011_0100_1010_1001;
  localparam logic [LONG_W-1:0]  LONG_INIT  = {
    54'b1111111001_1100100110_0001100101_0100010010_0001011111_1111,
    54'b010100_1010000000_1100011011_1111101111_1011110010_01000010
  };

  // Control between the top level and the keystream generator
  typedef struct packed {
    logic advance;  // an item moves into the result register this cycle
    logic reload;   // that item restarts the generators
    logic masked;   // that item uses the keystream
  } clbm_ctrl_t;

  // Feedback bits of eight steps of the short register; bit k is step k.
  // Taps stay below the eight fresh bits, so all come from the old state.
  function automatic logic [BYTE_W-1:0] short_fb8(input logic [SHORT_W-1:0] s);
    logic [BYTE_W-1:0] fb;
    for (int k = 0; k < BYTE_W; k++) begin
      fb[k] = s[k] ^ s[k+SHORT_TAP];
    end
    return fb;
  endfunction

  // Feedback bits of eight steps of the long register
  function automatic logic [BYTE_W-1:0] long_fb8(input logic [LONG_W-1:0] s);
    logic [BYTE_W-1:0] fb;
    for (int k = 0; k < BYTE_W; k++) begin
      fb[k] = s[k] ^ s[k+LONG_TAP];
    end
    return fb;
  endfunction

  // First step lands in the most significant bit
  function automatic logic [BYTE_W-1:0] bit_reverse8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[BYTE_W-1-k] = v[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/clbm_keystream.sv =====
// Two Fibonacci LFSRs (16 and 108 bits) stepped eight times per masked byte.
// Depends on clbm_pkg.
`default_nettype none

module clbm_keystream (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire clbm_pkg::clbm_ctrl_t       ctrl,
  output logic [clbm_pkg::BYTE_W-1:0]     ks_byte
);

  logic [clbm_pkg::SHORT_W-1:0] short_reg, short_next, short_cur;
  logic [clbm_pkg::LONG_W-1:0]  long_reg, long_next, long_cur;
  logic [clbm_pkg::BYTE_W-1:0]  short_fb, long_fb;

  // Select the starting state: reload uses the fixed initial patterns
  always_comb begin
    short_cur = ctrl.reload ? clbm_pkg::SHORT_INIT : short_reg;
    long_cur  = ctrl.reload ? clbm_pkg::LONG_INIT  : long_reg;
    short_fb  = clbm_pkg::short_fb8(short_cur);
    long_fb   = clbm_pkg::long_fb8(long_cur);
    ks_byte   = clbm_pkg::bit_reverse8(short_fb ^ long_fb);
  end

  // Step both registers eight times for a masked byte; reloads apply to all
  always_comb begin
    short_next = short_reg;
    long_next  = long_reg;
    if (ctrl.advance) begin
      if (ctrl.masked) begin
        short_next = {short_fb, short_cur[clbm_pkg::SHORT_W-1:clbm_pkg::BYTE_W]};
        long_next  = {long_fb, long_cur[clbm_pkg::LONG_W-1:clbm_pkg::BYTE_W]};
      end else begin
        short_next = short_cur;
        long_next  = long_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_reg <= clbm_pkg::SHORT_INIT;
      long_reg  <= clbm_pkg::LONG_INIT;
    end else begin
      short_reg <= short_next;
      long_reg  <= long_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/combined_lfsr_byte_masker_unit.sv =====
// Top level of the combined LFSR byte masker: stream ports, byte counter,
// input and result registers. Depends on clbm_pkg and clbm_keystream.
`default_nettype none

// XORs each byte of the stream with a keystream byte taken from a 16-bit and
// a 108-bit Fibonacci LFSR, both stepped eight times per masked byte. A word
// with s_tuser set reloads both generators and restarts the byte count before
// it is processed. Only the first mask_length bytes after a restart are
// masked (0 masks all); later bytes pass unchanged with m_tuser low. The
// block takes one word per cycle while the result side is not stalled: a
// word goes through an input register and then the result register, and
// the eight LFSR steps are a single layer of XOR gates between those two
// registers. The byte count saturates at 2^COUNT_BITS - 1. The user writes
// mask_length over the cfg port only while the block is idle; the block
// does not enforce this. cfg_ready is always high.
module combined_lfsr_byte_masker_unit #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  wire logic                          s_tuser,   // [0] first_byte
  // Result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,   // [7:0] out_byte
  output logic                               m_tuser,   // [0] was_masked
  // mask_length write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [clbm_pkg::MLEN_W-1:0]   cfg_data
);

  localparam int CMP_W = (COUNT_BITS > clbm_pkg::MLEN_W) ? COUNT_BITS : clbm_pkg::MLEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [clbm_pkg::MLEN_W-1:0] mask_length;
  logic [COUNT_BITS-1:0]       byte_count, byte_count_next, count_cur;

  logic                        in_valid;
  logic [clbm_pkg::BYTE_W-1:0] in_data;
  logic                        in_first;

  logic                        masked;
  logic [clbm_pkg::BYTE_W-1:0] ks_byte;
  clbm_pkg::clbm_ctrl_t        ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length <= '0;
    end else if (cfg_valid) begin
      mask_length <= cfg_data;
    end
  end

  // Move the held word forward whenever the result slot is free or draining
  assign ctrl.advance = in_valid && (!m_tvalid || m_tready);
  assign ctrl.reload  = in_first;
  assign ctrl.masked  = masked;
  assign s_tready     = !in_valid || ctrl.advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  // Decide masking against the count as seen by this byte
  always_comb begin
    count_cur = in_first ? '0 : byte_count;
    masked    = (mask_length == '0) || (CMP_W'(count_cur) < CMP_W'(mask_length));
    byte_count_next = byte_count;
    if (ctrl.advance) begin
      byte_count_next = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  clbm_keystream u_keystream (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .ks_byte (ks_byte)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      m_tdata <= masked ? (in_data ^ ks_byte) : in_data;
      m_tuser <= masked;
    end
  end

endmodule

`default_nettype wire

// ===== sv/clbm_checker.sv =====
// Port-level checks for combined_lfsr_byte_masker_unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module clbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [31:0] cfg_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input side never stalls while the result side can drain
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free result slot");

  // After a word is accepted while the result register is empty, that register turns valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid ##1 1'b1 |=> m_tvalid)
    else $error("accepted word did not reach the result register");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg write channel stalled");

endmodule

bind combined_lfsr_byte_masker_unit clbm_checker u_clbm_checker (.*);

`default_nettype wire
